// File: design/symmetric_fir_lowpass_core_defines.svh
// Assertion helpers shared by the filter core.
`ifndef SYMMETRIC_FIR_LOWPASS_CORE_DEFINES_SVH
`define SYMMETRIC_FIR_LOWPASS_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFIR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/sfir_pkg.sv
package sfir_pkg;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	// Control shared by every cell of the tap chain.
	typedef struct packed {
		logic shift;
		logic rotate;
	} sfir_cell_ctrl_t;

	// Control for the shared multiply-accumulate unit.
	typedef struct packed {
		logic clear;
		logic mul_en;
	} sfir_mac_ctrl_t;

endpackage

// File: design/sfir_tap_cell.sv
module sfir_tap_cell import sfir_pkg::*; #(
	parameter int W = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sfir_cell_ctrl_t     ctrl,
	input  logic signed [W-1:0] shift_d,
	input  logic signed [W-1:0] rot_d,
	output logic signed [W-1:0] q
);

	logic signed [W-1:0] tap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (ctrl.shift) begin
			tap_q <= shift_d;
		end else if (ctrl.rotate) begin
			tap_q <= rot_d;
		end
	end

	assign q = tap_q;

endmodule

// File: design/sfir_mac.sv
module sfir_mac import sfir_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 18,
	parameter int NTAPS       = 33
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sfir_mac_ctrl_t                ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic signed [COEF_BITS-1:0]   coef,
	output logic signed [SAMPLE_BITS-1:0] result,
	output logic                          sat
);

	localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W  = PROD_W + $clog2(NTAPS);
	localparam int FRAC   = COEF_BITS - 2;
	localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC - 1);
	localparam logic signed [ACC_W-1:0] MAXV =
		{{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] MINV = ~MAXV;

	logic signed [PROD_W-1:0] product_s1;
	logic                     pvalid_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  rounded;
	logic signed [ACC_W-1:0]  shifted;
	logic                     over;
	logic                     under;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_s1 <= 1'b0;
		end else begin
			pvalid_s1 <= ctrl.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			product_s1 <= sample * coef;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clear) begin
			acc_q <= '0;
		end else if (pvalid_s1) begin
			acc_q <= acc_q + ACC_W'(product_s1);
		end
	end

	// Adding half an LSB and shifting arithmetically rounds exact halves upwards.
	always_comb begin
		rounded = acc_q + HALF_LSB;
		shifted = rounded >>> FRAC;
		over    = shifted > MAXV;
		under   = shifted < MINV;
		sat     = over | under;
		if (over) begin
			result = MAXV[SAMPLE_BITS-1:0];
		end else if (under) begin
			result = MINV[SAMPLE_BITS-1:0];
		end else begin
			result = shifted[SAMPLE_BITS-1:0];
		end
	end

endmodule

// File: design/symmetric_fir_lowpass_core.sv
// Symmetric odd-length FIR low-pass with one shared multiply-accumulate unit.
// A sample word gives its result once the MAC has walked the tap chain; a new word
// is taken only after the drain and final steps have loaded the output register.
// Coefficient load words are taken one per cycle while the core is idle.
// Asynchronous active-low reset clears the delay line, the coefficient table
// and all control state.
module symmetric_fir_lowpass_core import sfir_pkg::*; #(
	parameter int HALF_TAPS   = 16,
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 18
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 cmd,
	input  logic signed [SAMPLE_BITS-1:0]        sample_in,
	input  logic [$clog2(HALF_TAPS + 1)-1:0]     coef_index,
	input  logic signed [COEF_BITS-1:0]          coef_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [SAMPLE_BITS-1:0]        sample_out,
	output logic                                 saturated
);

`include "symmetric_fir_lowpass_core_defines.svh"

	localparam int NTAPS  = 2 * HALF_TAPS + 1;
	localparam int CIDX_W = $clog2(HALF_TAPS + 1);
	localparam logic [CIDX_W-1:0] HALF_IDX = CIDX_W'(HALF_TAPS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	state_t                        state_q;
	logic [CIDX_W-1:0]             dist_q;
	logic                          up_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          saturated_q;

	logic signed [COEF_BITS-1:0]   coef_q [0:HALF_TAPS];
	logic signed [SAMPLE_BITS-1:0] tap [0:NTAPS-1];

	logic            accept;
	logic            take_sample;
	logic            take_load;
	logic            run_end;
	logic            out_load;
	sfir_cell_ctrl_t cell_ctrl;
	sfir_mac_ctrl_t  mac_ctrl;
	logic signed [SAMPLE_BITS-1:0] mac_result;
	logic                          mac_sat;

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid & in_ready;
	assign take_sample = accept & (cmd == CMD_SAMPLE);
	assign take_load   = accept & (cmd == CMD_LOAD) &
		({1'b0, coef_index} <= {1'b0, HALF_IDX});
	assign run_end     = (state_q == ST_RUN) & up_q & (dist_q == HALF_IDX);
	assign out_load    = (state_q == ST_FIN) & (!out_valid_q | out_ready);

	// A new word shifts in at the head; during the run the chain rotates so that
	// the head shows the samples from newest to oldest and ends where it began.
	assign cell_ctrl.shift  = take_sample;
	assign cell_ctrl.rotate = (state_q == ST_RUN);
	assign mac_ctrl.clear   = take_sample;
	assign mac_ctrl.mul_en  = (state_q == ST_RUN);

	for (genvar i = 0; i < NTAPS; i++) begin : g_tap
		logic signed [SAMPLE_BITS-1:0] shift_src;
		if (i == 0) begin : g_head
			assign shift_src = sample_in;
		end else begin : g_body
			assign shift_src = tap[i-1];
		end
		sfir_tap_cell #(
			.W(SAMPLE_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (cell_ctrl),
			.shift_d(shift_src),
			.rot_d  (tap[(i + 1) % NTAPS]),
			.q      (tap[i])
		);
	end

	sfir_mac #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_BITS  (COEF_BITS),
		.NTAPS      (NTAPS)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (mac_ctrl),
		.sample(tap[0]),
		.coef  (coef_q[dist_q]),
		.result(mac_result),
		.sat   (mac_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= HALF_TAPS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (take_load) begin
			coef_q[coef_index] <= coef_value;
		end
	end

	// The distance from the centre tap falls to zero and climbs back again.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			dist_q       <= '0;
			up_q         <= 1'b0;
			out_valid_q  <= 1'b0;
			sample_out_q <= '0;
			saturated_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q  <= 1'b1;
				sample_out_q <= mac_result;
				saturated_q  <= mac_sat;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take_sample) begin
						state_q <= ST_RUN;
						dist_q  <= HALF_IDX;
						up_q    <= 1'b0;
					end
				end
				ST_RUN: begin
					if (run_end) begin
						state_q <= ST_DRAIN;
					end else if (!up_q && dist_q == '0) begin
						up_q   <= 1'b1;
						dist_q <= dist_q + 1'b1;
					end else if (up_q) begin
						dist_q <= dist_q + 1'b1;
					end else begin
						dist_q <= dist_q - 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign saturated  = saturated_q;

	`SFIR_ASSERT_NEXT(a_busy_after_sample, clk, arst_n, take_sample, !in_ready, "core still ready after a sample word")
	`SFIR_ASSERT_SAME(a_dist_in_range, clk, arst_n, state_q == ST_RUN, dist_q <= HALF_IDX, "tap distance beyond the coefficient table")
	`SFIR_ASSERT_SAME(a_result_from_fin, clk, arst_n, $rose(out_valid_q), $past(state_q == ST_FIN), "result raised outside the final step")

endmodule

// File: verif/symmetric_fir_lowpass_core_tb.sv
module symmetric_fir_lowpass_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sfir_pkg::*;

	localparam int HALF_TAPS   = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS   = 18;
	localparam int NTAPS       = 2 * HALF_TAPS + 1;
	localparam int COEF_FRAC   = COEF_BITS - 2;
	localparam int IDX_BITS    = $clog2(HALF_TAPS + 1);
	localparam int RANDOM_WORDS = 2000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic [IDX_BITS-1:0]           coef_idx_t;

	typedef struct {
		sample_t value;
		logic    clipped;
	} filtered_t;

	class fir_tracker;
		coef_t       coefs [0:HALF_TAPS];
		sample_t     history [0:NTAPS-1];
		int unsigned head;
		filtered_t   pending_filtered [$];
		int          errors;
		int          samples_seen;
		int          clipped_seen;
		int          loads_seen;
		int          loads_ignored;
		int          results_checked;

		function new();
			foreach (coefs[i])
				coefs[i] = '0;
			foreach (history[i])
				history[i] = '0;
			head = 0;
			errors = 0;
			samples_seen = 0;
			clipped_seen = 0;
			loads_seen = 0;
			loads_ignored = 0;
			results_checked = 0;
		endfunction

		task report(input string msg);
			if (errors < 100)
				$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		function int outstanding();
			return pending_filtered.size();
		endfunction

		// Updates the filter state for one accepted word; a sample word also queues its output.
		function void take_word(input logic c, input sample_t s, input coef_idx_t idx,
				input coef_t cv);
			longint    acc;
			longint    rounded;
			int        tap_dist;
			int        slot;
			filtered_t res;
			if (c == CMD_LOAD) begin
				loads_seen++;
				if (idx <= HALF_TAPS)
					coefs[idx] = cv;
				else
					loads_ignored++;
				return;
			end
			samples_seen++;
			history[head] = s;
			acc = 0;
			for (int k = 0; k < NTAPS; k++) begin
				slot = (head + NTAPS - k) % NTAPS;
				tap_dist = (k >= HALF_TAPS) ? k - HALF_TAPS : HALF_TAPS - k;
				acc += longint'(coefs[tap_dist]) * longint'(history[slot]);
			end
			head = (head + 1) % NTAPS;
			// Round half up, then an arithmetic shift floors towards minus infinity.
			rounded = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
			res.clipped = 1'b0;
			if (rounded > longint'((1 << (SAMPLE_BITS - 1)) - 1)) begin
				rounded = (1 << (SAMPLE_BITS - 1)) - 1;
				res.clipped = 1'b1;
			end else if (rounded < -longint'(1 << (SAMPLE_BITS - 1))) begin
				rounded = -longint'(1 << (SAMPLE_BITS - 1));
				res.clipped = 1'b1;
			end
			if (res.clipped)
				clipped_seen++;
			res.value = sample_t'(rounded);
			pending_filtered.push_back(res);
		endfunction

		task check_filtered(input sample_t got_value, input logic got_clipped);
			filtered_t want;
			if (pending_filtered.size() == 0) begin
				report($sformatf("output word %0d with nothing expected", got_value));
				return;
			end
			want = pending_filtered.pop_front();
			results_checked++;
			if (got_value !== want.value)
				report($sformatf("sample_out %0d, expected %0d", got_value, want.value));
			if (got_clipped !== want.clipped)
				report($sformatf("saturated %0b, expected %0b", got_clipped, want.clipped));
		endtask
	endclass

	logic      clk;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	logic      cmd = CMD_SAMPLE;
	sample_t   sample_in = '0;
	coef_idx_t coef_index = '0;
	coef_t     coef_value = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	sample_t   sample_out;
	logic      saturated;

	fir_tracker tracker = new();
	bit gaps_on = 1'b1;
	bit hold_request = 1'b0;

	symmetric_fir_lowpass_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.sample_in  (sample_in),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.saturated  (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results still due", cycles,
			tracker.outstanding());
		$display("symmetric_fir_lowpass_core_tb NOT OK");
		$finish;
	end

	// Output side: checks each accepted word, then decides whether to take the next one.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				tracker.check_filtered(sample_out, saturated);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!arst_n) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= gaps_on ? ($urandom_range(0, 99) >= 12) : 1'b1;
			end
		end
	end

	task automatic send_word(input logic c, input sample_t s, input coef_idx_t idx,
			input coef_t cv);
		while (gaps_on && $urandom_range(0, 99) < 12) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		sample_in  <= s;
		coef_index <= idx;
		coef_value <= cv;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.take_word(c, s, idx, cv);
	endtask

	// The unused fields carry random junk, which the core must ignore.
	task automatic send_sample(input sample_t s);
		send_word(CMD_SAMPLE, s, coef_idx_t'($urandom), coef_t'($urandom));
	endtask

	task automatic send_load(input coef_idx_t idx, input coef_t cv);
		send_word(CMD_LOAD, sample_t'($urandom), idx, cv);
	endtask

	task automatic wait_drained();
		while (tracker.outstanding() != 0)
			@(posedge clk);
	endtask

	initial begin
		int      pick;
		sample_t s;
		coef_t   cv;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: cleared table, rounding at halves, clipping both ways, ignored loads.
		send_sample(16'sh7fff);
		send_load(0, 18'sd32768);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(16'sd3);
		send_load(0, 18'sd131071);
		send_sample(16'sh7fff);
		send_sample(-16'sd32768);
		send_load(0, -18'sd131072);
		send_sample(-16'sd32768);
		send_load(16, 18'sd131071);
		send_load(8, -18'sd131072);
		send_load(17, 18'sd12345);
		send_load(31, -18'sd1);
		for (int i = 0; i < 10; i++) begin
			case (i % 5)
				0: send_sample(16'sh7fff);
				1: send_sample(-16'sd32768);
				2: send_sample(16'sd0);
				3: send_sample(16'sd1);
				default: send_sample(-16'sd1);
			endcase
		end

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			gaps_on = !(i >= 1200 && i < 1500);
			if (i == 400)
				hold_request = 1'b1;
			if (i == 1000) begin
				in_valid <= 1'b0;
				@(posedge clk);
				wait_drained();
			end
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				// Mostly modest coefficients so that many outputs stay unclipped.
				if ($urandom_range(0, 2) == 0)
					cv = coef_t'($urandom);
				else
					cv = coef_t'(int'($urandom_range(0, 4095)) - 2048);
				if ($urandom_range(0, 4) == 0)
					send_load(coef_idx_t'($urandom_range(HALF_TAPS + 1, 31)), cv);
				else
					send_load(coef_idx_t'($urandom_range(0, HALF_TAPS)), cv);
			end else begin
				case ($urandom_range(0, 15))
					0: s = 16'sh7fff;
					1: s = -16'sd32768;
					default: s = sample_t'($urandom);
				endcase
				send_sample(s);
			end
		end
		in_valid <= 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("filtered %0d sample words (%0d clipped), checked %0d outputs",
			tracker.samples_seen, tracker.clipped_seen, tracker.results_checked);
		$display("loaded %0d coefficients, %0d of them out of range, %0d mismatches",
			tracker.loads_seen, tracker.loads_ignored, tracker.errors);
		if (tracker.errors == 0)
			$display("symmetric_fir_lowpass_core_tb OK");
		else
			$display("symmetric_fir_lowpass_core_tb NOT OK");
		$finish;
	end

endmodule
